@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define BTB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define BTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/btb2_pkg.sv @@
// Package: sizes, codes and shared types of the branch target buffer.
package btb2_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int PC_W    = 24;
    localparam int CNT_W   = 32;
    localparam int SLOT_W  = 10;
    localparam int EV_W    = 3;
    localparam int NSTAT   = 7;

    localparam int ST_HIT     = 0;
    localparam int ST_MISS    = 1;
    localparam int ST_RIGHT   = 2;
    localparam int ST_WRONG   = 3;
    localparam int ST_COLL    = 4;
    localparam int ST_STALL   = 5;
    localparam int ST_NOSTALL = 6;

    typedef logic [EV_W-1:0] t_event;
    localparam t_event EV_FIRST   = 3'd0;
    localparam t_event EV_HIT_NT  = 3'd1;
    localparam t_event EV_HIT_RT  = 3'd2;
    localparam t_event EV_HIT_WT  = 3'd3;
    localparam t_event EV_MISS_T  = 3'd4;
    localparam t_event EV_MISS_NT = 3'd5;

    typedef logic [1:0] t_pred;
    localparam t_pred PRED_00 = 2'b00;
    localparam t_pred PRED_01 = 2'b01;
    localparam t_pred PRED_10 = 2'b10;
    localparam t_pred PRED_11 = 2'b11;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_status;

    typedef struct packed {
        logic            valid;
        logic [PC_W-1:0] tag;
        logic [PC_W-1:0] target;
        t_pred           pred;
    } t_entry;

endpackage

@@ src/btb2_datapath.sv @@
// Datapath: entry memory, previous pc, classification and statistics counters.
module btb2_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btb2_pkg::t_cmd                i_cmd,
    output btb2_pkg::t_status             o_status,
    input  logic [btb2_pkg::PC_W-1:0]     i_pc,
    output logic [btb2_pkg::EV_W-1:0]     o_event_res,
    output logic                          o_collision,
    output logic [btb2_pkg::SLOT_W-1:0]   o_slot,
    output logic [1:0]                    o_pred_state,
    output logic [btb2_pkg::CNT_W-1:0]    o_hits,
    output logic [btb2_pkg::CNT_W-1:0]    o_misses,
    output logic [btb2_pkg::CNT_W-1:0]    o_rights,
    output logic [btb2_pkg::CNT_W-1:0]    o_wrongs,
    output logic [btb2_pkg::CNT_W-1:0]    o_collisions_total,
    output logic [btb2_pkg::CNT_W-1:0]    o_stalls,
    output logic [btb2_pkg::CNT_W-1:0]    o_no_stalls
);

    btb2_pkg::t_entry                 r_mem [btb2_pkg::ENTRIES];
    btb2_pkg::t_entry                 r_rd;
    logic [btb2_pkg::IDX_W-1:0]       r_clr_addr;
    logic [btb2_pkg::PC_W-1:0]        r_last_pc;
    logic                             r_last_valid;
    logic [btb2_pkg::PC_W-1:0]        r_cur_pc;
    logic [btb2_pkg::CNT_W-1:0]       r_cnt [btb2_pkg::NSTAT];
    btb2_pkg::t_event                 r_event;
    logic                             r_coll;
    logic [btb2_pkg::SLOT_W-1:0]      r_slot;
    btb2_pkg::t_pred                  r_pred;

    logic [btb2_pkg::IDX_W-1:0]       w_idx;
    logic [btb2_pkg::PC_W-1:0]        w_nxt;
    logic                             w_hit;
    logic                             w_taken;
    btb2_pkg::t_event                 w_event;
    logic                             w_coll;
    btb2_pkg::t_pred                  w_pred;
    logic [btb2_pkg::SLOT_W-1:0]      w_slot;
    logic                             w_wr_en;
    btb2_pkg::t_entry                 w_wr_entry;
    logic [btb2_pkg::NSTAT-1:0]       w_bump;

    assign w_idx   = r_last_pc[btb2_pkg::IDX_W+1:2];
    assign w_nxt   = r_last_pc + btb2_pkg::PC_W'(4);
    assign w_hit   = r_rd.valid && (r_rd.tag == r_last_pc);
    assign w_taken = (r_cur_pc != w_nxt);

    assign o_status.clr_last = (r_clr_addr == btb2_pkg::IDX_W'(btb2_pkg::ENTRIES - 1));

    always_comb begin
        w_event    = btb2_pkg::EV_FIRST;
        w_coll     = 1'b0;
        w_pred     = btb2_pkg::PRED_00;
        w_slot     = '0;
        w_wr_en    = 1'b0;
        w_wr_entry = r_rd;
        w_bump     = '0;
        if (r_last_valid) begin
            w_slot = btb2_pkg::SLOT_W'(w_idx);
            if (w_hit) begin
                w_bump[btb2_pkg::ST_HIT] = 1'b1;
                w_wr_en = 1'b1;
                if (!w_taken) begin
                    w_event = btb2_pkg::EV_HIT_NT;
                    w_bump[btb2_pkg::ST_WRONG] = 1'b1;
                    w_wr_entry.pred = (r_rd.pred == btb2_pkg::PRED_00) ?
                                      btb2_pkg::PRED_01 : btb2_pkg::PRED_11;
                end else if (r_cur_pc == r_rd.target) begin
                    w_event = btb2_pkg::EV_HIT_RT;
                    w_bump[btb2_pkg::ST_RIGHT]   = 1'b1;
                    w_bump[btb2_pkg::ST_NOSTALL] = 1'b1;
                    w_wr_entry.pred = (r_rd.pred == btb2_pkg::PRED_11) ?
                                      btb2_pkg::PRED_10 : btb2_pkg::PRED_00;
                end else begin
                    w_event = btb2_pkg::EV_HIT_WT;
                    w_coll  = 1'b1;
                    w_bump[btb2_pkg::ST_WRONG] = 1'b1;
                    w_bump[btb2_pkg::ST_STALL] = 1'b1;
                    w_bump[btb2_pkg::ST_COLL]  = 1'b1;
                    w_wr_entry.target = r_cur_pc;
                    w_wr_entry.pred   = btb2_pkg::PRED_00;
                end
                w_pred = w_wr_entry.pred;
            end else if (w_taken) begin
                w_event = btb2_pkg::EV_MISS_T;
                w_coll  = r_rd.valid;
                w_bump[btb2_pkg::ST_MISS]  = 1'b1;
                w_bump[btb2_pkg::ST_STALL] = 1'b1;
                w_bump[btb2_pkg::ST_COLL]  = r_rd.valid;
                w_wr_en           = 1'b1;
                w_wr_entry.valid  = 1'b1;
                w_wr_entry.tag    = r_last_pc;
                w_wr_entry.target = r_cur_pc;
                w_wr_entry.pred   = btb2_pkg::PRED_00;
            end else begin
                w_event = btb2_pkg::EV_MISS_NT;
                w_pred  = r_rd.valid ? r_rd.pred : btb2_pkg::PRED_00;
            end
        end
    end

    // entry memory: clearing pass after reset, one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.commit && w_wr_en) begin
            r_mem[w_idx] <= w_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_pc <= i_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pc    <= '0;
            r_last_valid <= 1'b0;
            for (int k = 0; k < btb2_pkg::NSTAT; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_last_pc    <= r_cur_pc;
            r_last_valid <= 1'b1;
            for (int k = 0; k < btb2_pkg::NSTAT; k++) begin
                if (w_bump[k] && (r_cnt[k] != '1)) begin
                    r_cnt[k] <= r_cnt[k] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_event <= w_event;
            r_coll  <= w_coll;
            r_slot  <= w_slot;
            r_pred  <= w_pred;
        end
    end

    assign o_event_res        = r_event;
    assign o_collision        = r_coll;
    assign o_slot             = r_slot;
    assign o_pred_state       = r_pred;
    assign o_hits             = r_cnt[btb2_pkg::ST_HIT];
    assign o_misses           = r_cnt[btb2_pkg::ST_MISS];
    assign o_rights           = r_cnt[btb2_pkg::ST_RIGHT];
    assign o_wrongs           = r_cnt[btb2_pkg::ST_WRONG];
    assign o_collisions_total = r_cnt[btb2_pkg::ST_COLL];
    assign o_stalls           = r_cnt[btb2_pkg::ST_STALL];
    assign o_no_stalls        = r_cnt[btb2_pkg::ST_NOSTALL];

endmodule

@@ src/btb2_ctrl.sv @@
// Controller: clearing pass, input transfer, evaluate and result handoff.
module btb2_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output btb2_pkg::t_cmd      o_cmd,
    input  btb2_pkg::t_status   i_status
);

    btb2_pkg::t_state r_state;
    btb2_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= btb2_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_ready     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            btb2_pkg::S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = btb2_pkg::S_IDLE;
                end
            end
            btb2_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = btb2_pkg::S_EVAL;
                end
            end
            btb2_pkg::S_EVAL: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = btb2_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = btb2_pkg::S_CLEAR;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

@@ src/branch_target_buffer_two_bit_core.sv @@
// Top level: branch target buffer with 2-bit state, controller plus datapath.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------------
//   trace in  | i_valid / o_ready  | i_pc
//   result    | o_valid / i_ready  | o_event_res, o_collision, o_slot,
//             |                    | o_pred_state, seven 32-bit counters
//
// Each item passes through IDLE (transfer plus registered entry read), then
// EVAL (evaluate and write back); o_ready stays low until EVAL commits.
// After reset a clearing pass over all 1024 entries runs with o_ready low.
// A result waiting at the output does not block the next transfer in;
// evaluation of that item holds until the output register frees.
module branch_target_buffer_two_bit_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [btb2_pkg::PC_W-1:0]     i_pc,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [btb2_pkg::EV_W-1:0]     o_event_res,
    output logic                          o_collision,
    output logic [btb2_pkg::SLOT_W-1:0]   o_slot,
    output logic [1:0]                    o_pred_state,
    output logic [btb2_pkg::CNT_W-1:0]    o_hits,
    output logic [btb2_pkg::CNT_W-1:0]    o_misses,
    output logic [btb2_pkg::CNT_W-1:0]    o_rights,
    output logic [btb2_pkg::CNT_W-1:0]    o_wrongs,
    output logic [btb2_pkg::CNT_W-1:0]    o_collisions_total,
    output logic [btb2_pkg::CNT_W-1:0]    o_stalls,
    output logic [btb2_pkg::CNT_W-1:0]    o_no_stalls
);

    btb2_pkg::t_cmd    w_cmd;
    btb2_pkg::t_status w_status;

    btb2_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    btb2_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_pc               (i_pc),
        .o_event_res        (o_event_res),
        .o_collision        (o_collision),
        .o_slot             (o_slot),
        .o_pred_state       (o_pred_state),
        .o_hits             (o_hits),
        .o_misses           (o_misses),
        .o_rights           (o_rights),
        .o_wrongs           (o_wrongs),
        .o_collisions_total (o_collisions_total),
        .o_stalls           (o_stalls),
        .o_no_stalls        (o_no_stalls)
    );

endmodule

@@ src/btb2_checker.sv @@
// Port-level checker for the branch target buffer, bound to the top level.
`include "assert_macros.svh"

module btb2_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [btb2_pkg::EV_W-1:0]     o_event_res,
    input logic                          o_collision,
    input logic [btb2_pkg::SLOT_W-1:0]   o_slot,
    input logic [1:0]                    o_pred_state,
    input logic [btb2_pkg::CNT_W-1:0]    o_hits,
    input logic [btb2_pkg::CNT_W-1:0]    o_stalls
);

    logic w_in_xfer;
    logic w_hold;
    logic w_coll_ev;
    logic w_first;
    logic w_first_clean;

    assign w_in_xfer     = i_valid && o_ready;
    assign w_hold        = o_valid && !i_ready;
    assign w_coll_ev     = (o_event_res == btb2_pkg::EV_HIT_WT) ||
                           (o_event_res == btb2_pkg::EV_MISS_T);
    assign w_first       = o_valid && (o_event_res == btb2_pkg::EV_FIRST);
    assign w_first_clean = (o_slot == '0) && !o_collision &&
                           (o_pred_state == btb2_pkg::PRED_00);

    // one item in flight: ready drops after an input transfer
    `BTB_ASSERT_NEXT(a_one_in_flight, w_in_xfer, !o_ready, "ready held after transfer")

    `BTB_ASSERT_NEXT(a_out_hold, w_hold, o_valid && $stable(o_hits), "result dropped")

    `BTB_ASSERT_SAME(a_coll_event, o_valid && o_collision, w_coll_ev, "collision on wrong event")

    `BTB_ASSERT_NEXT(a_stall_mono, 1'b1, o_stalls >= $past(o_stalls), "stall count decreased")

    `BTB_ASSERT_SAME(a_first_clean, w_first, w_first_clean, "first result not clean")

endmodule

bind branch_target_buffer_two_bit_core btb2_checker u_btb2_checker (.*);

@@ test/branch_target_buffer_two_bit_core_tb.sv @@
// Testbench: pc-trace stimulus, per-item BTB predictor and scoreboard for the core.
`timescale 1ns / 100ps

module branch_target_buffer_two_bit_core_tb;

    typedef struct packed {
        btb2_pkg::t_event                                 ev;
        logic                                             coll;
        logic [btb2_pkg::SLOT_W-1:0]                      slot;
        btb2_pkg::t_pred                                  pred;
        logic [btb2_pkg::NSTAT-1:0][btb2_pkg::CNT_W-1:0]  cnt;
    } t_outcome;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [btb2_pkg::PC_W-1:0]     i_pc = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [btb2_pkg::EV_W-1:0]     o_event_res;
    logic                          o_collision;
    logic [btb2_pkg::SLOT_W-1:0]   o_slot;
    logic [1:0]                    o_pred_state;
    logic [btb2_pkg::CNT_W-1:0]    o_hits;
    logic [btb2_pkg::CNT_W-1:0]    o_misses;
    logic [btb2_pkg::CNT_W-1:0]    o_rights;
    logic [btb2_pkg::CNT_W-1:0]    o_wrongs;
    logic [btb2_pkg::CNT_W-1:0]    o_collisions_total;
    logic [btb2_pkg::CNT_W-1:0]    o_stalls;
    logic [btb2_pkg::CNT_W-1:0]    o_no_stalls;

    branch_target_buffer_two_bit_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_pc               (i_pc),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_event_res        (o_event_res),
        .o_collision        (o_collision),
        .o_slot             (o_slot),
        .o_pred_state       (o_pred_state),
        .o_hits             (o_hits),
        .o_misses           (o_misses),
        .o_rights           (o_rights),
        .o_wrongs           (o_wrongs),
        .o_collisions_total (o_collisions_total),
        .o_stalls           (o_stalls),
        .o_no_stalls        (o_no_stalls)
    );

    // predictor state
    bit                          ent_valid  [btb2_pkg::ENTRIES];
    bit [btb2_pkg::PC_W-1:0]     ent_tag    [btb2_pkg::ENTRIES];
    bit [btb2_pkg::PC_W-1:0]     ent_target [btb2_pkg::ENTRIES];
    btb2_pkg::t_pred             ent_pred   [btb2_pkg::ENTRIES];
    bit [btb2_pkg::PC_W-1:0]     last_pc;
    bit                          have_last;
    bit [btb2_pkg::CNT_W-1:0]    stat_cnt   [btb2_pkg::NSTAT];

    logic [btb2_pkg::PC_W-1:0]   pc_q[$];
    t_outcome                    outcome_q[$];
    int                          mismatch_cnt = 0;

    // trace generator loops
    bit [btb2_pkg::PC_W-1:0]     loop_head [8];
    bit [btb2_pkg::PC_W-1:0]     loop_br   [8];
    int                          loop_len  [8];

    function automatic void bump_stat(input int k);
        if (stat_cnt[k] != '1)
            stat_cnt[k] = stat_cnt[k] + 1'b1;
    endfunction

    function automatic t_outcome classify_transition(input logic [btb2_pkg::PC_W-1:0] s);
        t_outcome                     r;
        logic [btb2_pkg::PC_W-1:0]    p;
        logic [btb2_pkg::PC_W-1:0]    nxt;
        logic [btb2_pkg::IDX_W-1:0]   idx;
        logic                         hit;
        r = '0;
        r.ev = btb2_pkg::EV_FIRST;
        if (have_last) begin
            p   = last_pc;
            nxt = p + btb2_pkg::PC_W'(4);
            idx = p[btb2_pkg::IDX_W+1:2];
            hit = ent_valid[idx] && (ent_tag[idx] == p);
            r.slot = idx;
            if (hit) begin
                bump_stat(btb2_pkg::ST_HIT);
                if (s == nxt) begin
                    r.ev = btb2_pkg::EV_HIT_NT;
                    bump_stat(btb2_pkg::ST_WRONG);
                    ent_pred[idx] = (ent_pred[idx] == btb2_pkg::PRED_00) ?
                                    btb2_pkg::PRED_01 : btb2_pkg::PRED_11;
                end else if (s == ent_target[idx]) begin
                    r.ev = btb2_pkg::EV_HIT_RT;
                    bump_stat(btb2_pkg::ST_RIGHT);
                    bump_stat(btb2_pkg::ST_NOSTALL);
                    ent_pred[idx] = (ent_pred[idx] == btb2_pkg::PRED_11) ?
                                    btb2_pkg::PRED_10 : btb2_pkg::PRED_00;
                end else begin
                    r.ev   = btb2_pkg::EV_HIT_WT;
                    r.coll = 1'b1;
                    bump_stat(btb2_pkg::ST_WRONG);
                    bump_stat(btb2_pkg::ST_STALL);
                    bump_stat(btb2_pkg::ST_COLL);
                    ent_target[idx] = s;
                    ent_pred[idx]   = btb2_pkg::PRED_00;
                end
                r.pred = ent_pred[idx];
            end else if (s != nxt) begin
                r.ev = btb2_pkg::EV_MISS_T;
                bump_stat(btb2_pkg::ST_MISS);
                bump_stat(btb2_pkg::ST_STALL);
                if (ent_valid[idx]) begin
                    r.coll = 1'b1;
                    bump_stat(btb2_pkg::ST_COLL);
                end
                ent_valid[idx]  = 1'b1;
                ent_tag[idx]    = p;
                ent_target[idx] = s;
                ent_pred[idx]   = btb2_pkg::PRED_00;
                r.pred = btb2_pkg::PRED_00;
            end else begin
                r.ev   = btb2_pkg::EV_MISS_NT;
                r.pred = ent_valid[idx] ? ent_pred[idx] : btb2_pkg::PRED_00;
            end
        end
        last_pc   = s;
        have_last = 1'b1;
        for (int i = 0; i < btb2_pkg::NSTAT; i++)
            r.cnt[i] = stat_cnt[i];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [btb2_pkg::CNT_W-1:0] want,
                               input logic [btb2_pkg::CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // new set of loops; some share low bits with the previous one to alias slots
    task automatic build_loops();
        bit [11:0] high;
        bit [11:0] low;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 3))
                0: high = 12'h000;
                1: high = 12'hFFF;
                2: high = 12'h001;
                default: high = 12'($urandom_range(0, 4095));
            endcase
            if (k > 0 && $urandom_range(0, 3) == 0) begin
                low         = loop_head[k-1][11:0];
                loop_len[k] = loop_len[k-1];
            end else begin
                low         = 12'($urandom_range(0, 1023) << 2);
                loop_len[k] = $urandom_range(1, 10);
                if ($urandom_range(0, 19) == 0)
                    low[1:0] = 2'($urandom_range(0, 3));
            end
            loop_head[k] = {high, low};
            loop_br[k]   = loop_head[k] + btb2_pkg::PC_W'(4 * loop_len[k]);
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // stimulus and end of run
    initial begin
        bit [btb2_pkg::PC_W-1:0] cur;
        bit [btb2_pkg::PC_W-1:0] nxt;
        int                      r;
        int                      found;
        int                      run_len;
        pc_q = '{24'h000000, 24'h000004, 24'h000100, 24'h000004, 24'h000008,
                 24'h000004, 24'h000008, 24'h000004, 24'h000100, 24'h000004,
                 24'h000008, 24'h000004, 24'h000200, 24'hFFFFFF, 24'hFFFFFC,
                 24'h000000, 24'h000200, 24'h000204, 24'h001200, 24'h005000,
                 24'h005004, 24'hAAAAAA, 24'h555555};
        run_len = 0;
        for (int n = 0; n < 450; n++) begin
            if (n % 100 == 0) begin
                build_loops();
                cur = loop_head[0];
                pc_q.push_back(cur);
                continue;
            end
            r = $urandom_range(0, 99);
            found = -1;
            for (int k = 0; k < 8; k++)
                if (found < 0 && loop_br[k] == cur)
                    found = k;
            if (found >= 0) begin
                if (r < 70)
                    nxt = loop_head[found];
                else if (r < 80)
                    nxt = loop_head[$urandom_range(0, 7)];
                else
                    nxt = cur + btb2_pkg::PC_W'(4);
                run_len = 0;
            end else begin
                if (r < 88 && run_len < 16) begin
                    nxt = cur + btb2_pkg::PC_W'(4);
                    run_len++;
                end else if (r < 94 || run_len >= 16) begin
                    nxt = loop_head[$urandom_range(0, 7)];
                    run_len = 0;
                end else begin
                    nxt = btb2_pkg::PC_W'($urandom());
                    run_len = 0;
                end
            end
            pc_q.push_back(nxt);
            cur = nxt;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pc_q.size() != 0 || i_valid || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pc_q.size() != 0) begin
                i_valid <= 1'b1;
                i_pc    <= pc_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int rx_mode = 0;
    int rx_cycle = 0;
    int rx_stall = 0;

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0)
            rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_stall > 0) begin
                    i_ready  <= 1'b0;
                    rx_stall <= rx_stall - 1;
                end else begin
                    i_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_stall <= $urandom_range(1, 20);
                end
            end
        endcase
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result transfer expected none actual event %0h",
                             $time, o_event_res);
                    mismatch_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("event_res", btb2_pkg::CNT_W'(want.ev),
                                btb2_pkg::CNT_W'(o_event_res));
                    check_field("collision", btb2_pkg::CNT_W'(want.coll),
                                btb2_pkg::CNT_W'(o_collision));
                    check_field("slot", btb2_pkg::CNT_W'(want.slot),
                                btb2_pkg::CNT_W'(o_slot));
                    check_field("pred_state", btb2_pkg::CNT_W'(want.pred),
                                btb2_pkg::CNT_W'(o_pred_state));
                    check_field("hits", want.cnt[btb2_pkg::ST_HIT], o_hits);
                    check_field("misses", want.cnt[btb2_pkg::ST_MISS], o_misses);
                    check_field("rights", want.cnt[btb2_pkg::ST_RIGHT], o_rights);
                    check_field("wrongs", want.cnt[btb2_pkg::ST_WRONG], o_wrongs);
                    check_field("collisions_total", want.cnt[btb2_pkg::ST_COLL],
                                o_collisions_total);
                    check_field("stalls", want.cnt[btb2_pkg::ST_STALL], o_stalls);
                    check_field("no_stalls", want.cnt[btb2_pkg::ST_NOSTALL], o_no_stalls);
                end
            end
            if (i_valid && o_ready)
                outcome_q.push_back(classify_transition(i_pc));
        end
    end

endmodule
